// File: rtl/core/sacp_pkg.sv
// shared types, register indexes and defaults of the set-associative cache
`default_nettype none
package sacp_pkg;

  // default sizes
  localparam int unsigned DEF_ADDR_BITS    = 48;
  localparam int unsigned DEF_MAX_SET_BITS = 10;
  localparam int unsigned DEF_NUM_WAYS     = 8;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 5;

  // way count as written, wide enough to compare against up to sixteen ways
  localparam int unsigned WAYS_CNT_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LRU_POLICY      = 3'd0,
    CFG_PREFETCH_ENABLE = 3'd1,
    CFG_BLOCK_OFFSET    = 3'd2,
    CFG_SET_INDEX       = 3'd3,
    CFG_WAYS_IN_USE     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic       lru_policy;
    logic       prefetch_enable;
    logic [4:0] block_offset_bits;
    logic [3:0] set_index_bits;
    logic [3:0] ways_in_use;
  } cfg_t;

  localparam logic [4:0] RST_BLOCK_OFFSET = 5'd5;
  localparam logic [3:0] RST_SET_INDEX    = 4'd0;
  localparam logic [3:0] RST_WAYS_IN_USE  = 4'd8;

endpackage
`default_nettype wire

// File: rtl/core/sacp_ram.sv
// generic single write port ram with registered read
`default_nettype none
module sacp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sacp_front.sv
// front end: address split for demand and next-line block, two-entry queue
`default_nettype none
module sacp_front
  import sacp_pkg::*;
#(
  parameter int unsigned ADDR_BITS    = DEF_ADDR_BITS,
  parameter int unsigned MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int unsigned SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
  parameter int unsigned ENT_W        = 1 + 2 * (SET_W + ADDR_BITS)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cfg_t                 cfg_i,
  input  wire logic                 busy_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [ADDR_BITS-1:0] address_i,
  input  wire logic                 is_write_i,
  output logic                      q_valid_o,
  output logic      [ENT_W-1:0]     q_entry_o,
  input  wire logic                 q_pop_i
);

  logic [ENT_W-1:0] ent_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             push;
  logic [3:0]       sb_eff;
  logic [ADDR_BITS-1:0] next_addr;
  logic [SET_W+ADDR_BITS-1:0] dsplit, psplit;

  // split an address into set index and tag
  function automatic logic [SET_W+ADDR_BITS-1:0] split(
    input logic [ADDR_BITS-1:0] addr,
    input logic [4:0]           bob,
    input logic [3:0]           sb
  );
    logic [ADDR_BITS-1:0] blk;
    logic [SET_W-1:0]     mask;
    begin
      blk = addr >> bob;
      for (int i = 0; i < SET_W; i++) begin
        mask[i] = (i < int'(sb));
      end
      split = {blk[SET_W-1:0] & mask, blk >> sb};
    end
  endfunction

  // effective set bits and the next-line address
  always_comb begin
    if ({1'b0, cfg_i.set_index_bits} > 5'(MAX_SET_BITS)) begin
      sb_eff = 4'(MAX_SET_BITS);
    end else begin
      sb_eff = cfg_i.set_index_bits;
    end
    next_addr = address_i + (ADDR_BITS'(1) << cfg_i.block_offset_bits);
    dsplit    = split(address_i, cfg_i.block_offset_bits, sb_eff);
    psplit    = split(next_addr, cfg_i.block_offset_bits, sb_eff);
  end

  assign in_stall_o = busy_i || (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_entry_o  = ent_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= {is_write_i, psplit, dsplit};
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sacp_back.sv
// back end: set read-modify-write, replacement, counters and result register
`default_nettype none
module sacp_back
  import sacp_pkg::*;
#(
  parameter int unsigned ADDR_BITS    = DEF_ADDR_BITS,
  parameter int unsigned MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int unsigned NUM_WAYS     = DEF_NUM_WAYS,
  parameter int unsigned SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
  parameter int unsigned ENT_W        = 1 + 2 * (SET_W + ADDR_BITS)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  output logic                  busy_o,
  input  wire logic             q_valid_i,
  input  wire logic [ENT_W-1:0] q_entry_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  hit_o,
  output logic                  demand_fill_o,
  output logic                  prefetch_fill_o,
  output logic                  memory_write_o,
  output logic      [31:0]      reads_total_o,
  output logic      [31:0]      writes_total_o,
  output logic      [31:0]      hits_total_o,
  output logic      [31:0]      misses_total_o
);

  localparam int unsigned NUM_SETS = 1 << MAX_SET_BITS;
  localparam int unsigned AGE_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned ROW_W    = NUM_WAYS * (1 + AGE_W + ADDR_BITS);
  localparam int unsigned TAG_LSB  = NUM_WAYS * (1 + AGE_W);
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(NUM_WAYS - 1);

  typedef enum logic [5:0] {
    ST_CLR  = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_DUPD = 6'b000100,
    ST_PRD  = 6'b001000,
    ST_PUPD = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [SET_W-1:0]     clr_cnt_q;
  logic [SET_W-1:0]     dset_q, pset_q;
  logic [ADDR_BITS-1:0] dtag_q, ptag_q;
  logic                 wr_q, hit_q, pf_q;
  logic [31:0]          reads_q, writes_q, hits_q, misses_q;
  logic                 out_valid_q;

  logic                 ram_we, ram_re;
  logic [SET_W-1:0]     ram_waddr, ram_raddr;
  logic [ROW_W-1:0]     ram_wdata, ram_rdata;

  logic [NUM_WAYS-1:0]  valid, n_valid, in_use;
  logic [AGE_W-1:0]     age [NUM_WAYS];
  logic [AGE_W-1:0]     n_age [NUM_WAYS];
  logic [ADDR_BITS-1:0] tag [NUM_WAYS];
  logic [ADDR_BITS-1:0] n_tag [NUM_WAYS];
  logic [ADDR_BITS-1:0] cur_tag;
  logic [WAYS_CNT_W-1:0] ways_eff;
  logic                 hit_found, inv_found;
  logic [WAY_W-1:0]     hit_way, inv_way, max_way, victim;
  logic [AGE_W-1:0]     max_age, prev_age;
  logic                 out_load;

  // queue entry fields
  logic [SET_W-1:0]     e_dset, e_pset;
  logic [ADDR_BITS-1:0] e_dtag, e_ptag;
  logic                 e_wr;
  assign {e_wr, e_pset, e_ptag, e_dset, e_dtag} = q_entry_i;

  sacp_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // effective associativity
  always_comb begin
    if (cfg_i.ways_in_use == 4'd0) begin
      ways_eff = WAYS_CNT_W'(1);
    end else if ({1'b0, cfg_i.ways_in_use} > WAYS_CNT_W'(NUM_WAYS)) begin
      ways_eff = WAYS_CNT_W'(NUM_WAYS);
    end else begin
      ways_eff = {1'b0, cfg_i.ways_in_use};
    end
  end

  // row unpack, lookup and victim choice
  always_comb begin
    cur_tag   = state_q[4] ? ptag_q : dtag_q;
    hit_found = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      valid[w]  = ram_rdata[w];
      age[w]    = ram_rdata[NUM_WAYS + w*AGE_W +: AGE_W];
      tag[w]    = ram_rdata[TAG_LSB + w*ADDR_BITS +: ADDR_BITS];
      in_use[w] = (WAYS_CNT_W'(w) < ways_eff);
    end
    // lowest way wins
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (in_use[w] && valid[w] && (tag[w] == cur_tag)) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(w);
      end
      if (in_use[w] && !valid[w]) begin
        inv_found = 1'b1;
        inv_way   = WAY_W'(w);
      end
    end
    max_age = age[0];
    max_way = '0;
    for (int w = 1; w < NUM_WAYS; w++) begin
      if (in_use[w] && (age[w] > max_age)) begin
        max_age = age[w];
        max_way = WAY_W'(w);
      end
    end
    victim   = inv_found ? inv_way : max_way;
    prev_age = age[hit_way];
  end

  // new row contents
  always_comb begin
    n_valid = valid;
    for (int w = 0; w < NUM_WAYS; w++) begin
      n_age[w] = age[w];
      n_tag[w] = tag[w];
    end
    if (hit_found) begin
      // lru touch on demand hits only
      if (cfg_i.lru_policy && state_q[2]) begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (in_use[w] && (WAY_W'(w) != hit_way) && valid[w] && (age[w] < prev_age)) begin
            n_age[w] = age[w] + AGE_W'(1);
          end
        end
        n_age[hit_way] = '0;
      end
    end else begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (in_use[w] && (WAY_W'(w) != victim) && valid[w] && (age[w] < AGE_MAX)) begin
          n_age[w] = age[w] + AGE_W'(1);
        end
      end
      n_valid[victim] = 1'b1;
      n_tag[victim]   = cur_tag;
      n_age[victim]   = '0;
    end
    ram_wdata = '0;
    if (!state_q[0]) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        ram_wdata[w]                               = n_valid[w];
        ram_wdata[NUM_WAYS + w*AGE_W +: AGE_W]     = n_age[w];
        ram_wdata[TAG_LSB + w*ADDR_BITS +: ADDR_BITS] = n_tag[w];
      end
    end
  end

  // memory port control
  assign ram_we    = state_q[0] || state_q[2] || state_q[4];
  assign ram_waddr = state_q[0] ? clr_cnt_q : (state_q[2] ? dset_q : pset_q);
  assign q_pop_o   = (state_q == ST_IDLE) && q_valid_i;
  assign ram_re    = q_pop_o || (state_q == ST_PRD);
  assign ram_raddr = (state_q == ST_PRD) ? pset_q : e_dset;
  assign busy_o    = (state_q == ST_CLR);
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR: begin
        if (clr_cnt_q == SET_W'(NUM_SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          state_d = ST_DUPD;
        end
      end
      ST_DUPD: begin
        if (!hit_found && cfg_i.prefetch_enable) begin
          state_d = ST_PRD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_PRD:  state_d = ST_PUPD;
      ST_PUPD: state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLR;
    endcase
  end

  // control state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_cnt_q   <= '0;
      reads_q     <= '0;
      writes_q    <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLR) begin
        clr_cnt_q <= clr_cnt_q + SET_W'(1);
      end
      if (state_q == ST_DUPD) begin
        if (wr_q && (writes_q != '1)) begin
          writes_q <= writes_q + 32'd1;
        end
        if (hit_found) begin
          if (hits_q != '1) begin
            hits_q <= hits_q + 32'd1;
          end
        end else begin
          if (misses_q != '1) begin
            misses_q <= misses_q + 32'd1;
          end
          if (reads_q != '1) begin
            reads_q <= reads_q + 32'd1;
          end
        end
      end
      if ((state_q == ST_PUPD) && !hit_found && (reads_q != '1)) begin
        reads_q <= reads_q + 32'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item fields and result register
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      dset_q <= e_dset;
      dtag_q <= e_dtag;
      pset_q <= e_pset;
      ptag_q <= e_ptag;
      wr_q   <= e_wr;
      pf_q   <= 1'b0;
    end
    if (state_q == ST_DUPD) begin
      hit_q <= hit_found;
    end
    if (state_q == ST_PUPD) begin
      pf_q <= !hit_found;
    end
    if (out_load) begin
      hit_o           <= hit_q;
      demand_fill_o   <= !hit_q;
      prefetch_fill_o <= pf_q;
      memory_write_o  <= wr_q;
      reads_total_o   <= reads_q;
      writes_total_o  <= writes_q;
      hits_total_o    <= hits_q;
      misses_total_o  <= misses_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_pupd_after_prd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUPD) |-> $past(state_q == ST_PRD))
    else $error("prefetch update without its read");
  a_pf_only_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && pf_q) |-> !hit_q)
    else $error("prefetch fill after a demand hit");
  a_hits_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (hits_q >= $past(hits_q)))
    else $error("hit counter went down");
  a_no_pop_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !q_pop_o)
    else $error("item taken during clearing pass");
`endif

endmodule
`default_nettype wire

// File: rtl/core/set_assoc_cache_with_prefetch_top.sv
// top level of the set-associative cache model with next-line prefetch
//
// Input channel: in_valid_i / in_stall_o carry one access (address, read or
// write); a transfer happens at a clock edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i carry one result per access: hit,
// demand fill, prefetch fill, write-through flag and the four running counters.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i; write
// only while no access is in flight.
// Each access passes the two-entry queue, then the set read, demand update and
// result states, with a prefetch read and prefetch update between the last two
// after a miss when prefetch is enabled. One access is processed at a time; the
// set memory is read and written once per set touched.
// Reset: the set memory is cleared one set per cycle, all 2**MAX_SET_BITS sets
// (1024 by default) while in_stall_o stays high; configuration writes are taken.
// A stalled output holds its result; one further access waits in the back end
// and up to two more queue behind it before in_stall_o rises.
`default_nettype none
module set_assoc_cache_with_prefetch_top
  import sacp_pkg::*;
#(
  parameter int unsigned ADDR_BITS    = DEF_ADDR_BITS,
  parameter int unsigned MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int unsigned NUM_WAYS     = DEF_NUM_WAYS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [ADDR_BITS-1:0]  address_i,
  input  wire logic                  is_write_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       hit_o,
  output logic                       demand_fill_o,
  output logic                       prefetch_fill_o,
  output logic                       memory_write_o,
  output logic      [31:0]           reads_total_o,
  output logic      [31:0]           writes_total_o,
  output logic      [31:0]           hits_total_o,
  output logic      [31:0]           misses_total_o
);

  localparam int unsigned SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned ENT_W = 1 + 2 * (SET_W + ADDR_BITS);

  cfg_t             cfg_q;
  logic             busy, q_valid, q_pop;
  logic [ENT_W-1:0] q_entry;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lru_policy        <= 1'b0;
      cfg_q.prefetch_enable   <= 1'b0;
      cfg_q.block_offset_bits <= RST_BLOCK_OFFSET;
      cfg_q.set_index_bits    <= RST_SET_INDEX;
      cfg_q.ways_in_use       <= RST_WAYS_IN_USE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LRU_POLICY:      cfg_q.lru_policy        <= cfg_wdata_i[0];
        CFG_PREFETCH_ENABLE: cfg_q.prefetch_enable   <= cfg_wdata_i[0];
        CFG_BLOCK_OFFSET:    cfg_q.block_offset_bits <= cfg_wdata_i[4:0];
        CFG_SET_INDEX:       cfg_q.set_index_bits    <= cfg_wdata_i[3:0];
        CFG_WAYS_IN_USE:     cfg_q.ways_in_use       <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  sacp_front #(
    .ADDR_BITS    (ADDR_BITS),
    .MAX_SET_BITS (MAX_SET_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .busy_i     (busy),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .address_i  (address_i),
    .is_write_i (is_write_i),
    .q_valid_o  (q_valid),
    .q_entry_o  (q_entry),
    .q_pop_i    (q_pop)
  );

  sacp_back #(
    .ADDR_BITS    (ADDR_BITS),
    .MAX_SET_BITS (MAX_SET_BITS),
    .NUM_WAYS     (NUM_WAYS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .busy_o          (busy),
    .q_valid_i       (q_valid),
    .q_entry_i       (q_entry),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hit_o           (hit_o),
    .demand_fill_o   (demand_fill_o),
    .prefetch_fill_o (prefetch_fill_o),
    .memory_write_o  (memory_write_o),
    .reads_total_o   (reads_total_o),
    .writes_total_o  (writes_total_o),
    .hits_total_o    (hits_total_o),
    .misses_total_o  (misses_total_o)
  );

endmodule
`default_nettype wire

// File: bench/set_assoc_cache_with_prefetch_top_test.sv
// self-checking testbench of the set-associative cache with next-line prefetch
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_cache_with_prefetch_top_test;
  import sacp_pkg::*;

  localparam int unsigned ABITS = DEF_ADDR_BITS;
  localparam int unsigned SET_BITS_MAX = DEF_MAX_SET_BITS;
  localparam int unsigned WAYS = DEF_NUM_WAYS;
  localparam int unsigned LINES = (1 << SET_BITS_MAX) * WAYS;
  localparam logic [2:0] RANK_MAX = 3'(WAYS - 1);
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = CFG_IDX_W'(CFG_WAYS_IN_USE) + 1'b1;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES = 12;

  typedef struct {
    logic        hit;
    logic        demand_fill;
    logic        prefetch_fill;
    logic        memory_write;
    logic [31:0] reads;
    logic [31:0] writes;
    logic [31:0] hits;
    logic [31:0] misses;
  } access_result_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic in_valid_i, in_stall_o;
  logic [ABITS-1:0] address_i;
  logic is_write_i;
  logic out_valid_o, out_stall_i;
  logic hit_o, demand_fill_o, prefetch_fill_o, memory_write_o;
  logic [31:0] reads_total_o, writes_total_o, hits_total_o, misses_total_o;

  set_assoc_cache_with_prefetch_top DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .address_i, .is_write_i,
    .out_valid_o, .out_stall_i, .hit_o, .demand_fill_o, .prefetch_fill_o,
    .memory_write_o, .reads_total_o, .writes_total_o, .hits_total_o,
    .misses_total_o
  );

  // predicted cache contents and settings
  logic            line_ok   [LINES];
  logic [ABITS-1:0] line_tag [LINES];
  logic [2:0]      line_rank [LINES];
  logic [31:0]     cnt_reads, cnt_writes, cnt_hits, cnt_misses;
  cfg_t            model_cfg;

  access_result_t  pending_results[$];
  logic [ABITS-1:0] hot_addr[16];
  int unsigned     send_idle_pct, recv_stall_pct;
  int unsigned     fail_count;
  int unsigned     quiet_cycles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int eff_ways();
    if (model_cfg.ways_in_use == 0) return 1;
    return (model_cfg.ways_in_use > WAYS) ? WAYS : int'(model_cfg.ways_in_use);
  endfunction

  function automatic int eff_set_bits();
    return (model_cfg.set_index_bits > SET_BITS_MAX) ? SET_BITS_MAX
                                                     : int'(model_cfg.set_index_bits);
  endfunction

  function automatic void sat_inc(ref logic [31:0] c);
    if (c != '1) c = c + 1'b1;
  endfunction

  // split an address and search its set; returns the matching way or -1
  function automatic int find_line(input logic [ABITS-1:0] a, output int base,
                                   output logic [ABITS-1:0] t);
    logic [ABITS-1:0] blk;
    int sb, nways;
    sb = eff_set_bits();
    nways = eff_ways();
    blk = a >> model_cfg.block_offset_bits;
    base = int'(blk & ((ABITS'(1) << sb) - 1'b1)) * WAYS;
    t = blk >> sb;
    for (int w = 0; w < nways; w++)
      if (line_ok[base + w] && line_tag[base + w] == t) return w;
    return -1;
  endfunction

  // place a line in the first empty way, else over the oldest one
  function automatic void fill_line(int base, logic [ABITS-1:0] t);
    int nways, victim;
    bit found;
    logic [2:0] oldest;
    nways = eff_ways();
    victim = 0;
    found = 0;
    for (int w = 0; w < nways; w++)
      if (!found && !line_ok[base + w]) begin
        victim = w;
        found = 1;
      end
    if (!found) begin
      oldest = line_rank[base];
      for (int w = 1; w < nways; w++)
        if (line_rank[base + w] > oldest) begin
          oldest = line_rank[base + w];
          victim = w;
        end
    end
    line_ok[base + victim] = 1'b1;
    line_tag[base + victim] = t;
    line_rank[base + victim] = '0;
    for (int w = 0; w < nways; w++)
      if (w != victim && line_ok[base + w] && line_rank[base + w] < RANK_MAX)
        line_rank[base + w]++;
  endfunction

  function automatic access_result_t cache_access(logic [ABITS-1:0] a, logic wr);
    access_result_t r;
    int way, base, nways;
    logic [ABITS-1:0] t, next_addr;
    logic [2:0] prev;
    r = '{default: '0};
    way = find_line(a, base, t);
    if (wr) sat_inc(cnt_writes);
    if (way >= 0) begin
      r.hit = 1'b1;
      sat_inc(cnt_hits);
      // lru: hit line becomes newest, younger lines move back one
      if (model_cfg.lru_policy) begin
        nways = eff_ways();
        prev = line_rank[base + way];
        line_rank[base + way] = '0;
        for (int w = 0; w < nways; w++)
          if (w != way && line_ok[base + w] && line_rank[base + w] < prev)
            line_rank[base + w]++;
      end
    end else begin
      sat_inc(cnt_misses);
      sat_inc(cnt_reads);
      fill_line(base, t);
      if (model_cfg.prefetch_enable) begin
        next_addr = a + (ABITS'(1) << model_cfg.block_offset_bits);
        if (find_line(next_addr, base, t) < 0) begin
          sat_inc(cnt_reads);
          fill_line(base, t);
          r.prefetch_fill = 1'b1;
        end
      end
    end
    r.demand_fill = ~r.hit;
    r.memory_write = wr;
    r.reads = cnt_reads;
    r.writes = cnt_writes;
    r.hits = cnt_hits;
    r.misses = cnt_misses;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // register write, idle only; called at a clock edge
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    case (idx)
      CFG_LRU_POLICY:      model_cfg.lru_policy = d[0];
      CFG_PREFETCH_ENABLE: model_cfg.prefetch_enable = d[0];
      CFG_BLOCK_OFFSET:    model_cfg.block_offset_bits = d[4:0];
      CFG_SET_INDEX:       model_cfg.set_index_bits = d[3:0];
      CFG_WAYS_IN_USE:     model_cfg.ways_in_use = d[3:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_all(logic lru, logic pf, logic [4:0] bo, logic [3:0] sb,
                         logic [3:0] nw);
    set_reg(CFG_LRU_POLICY, CFG_DATA_W'(lru));
    set_reg(CFG_PREFETCH_ENABLE, CFG_DATA_W'(pf));
    set_reg(CFG_BLOCK_OFFSET, bo);
    set_reg(CFG_SET_INDEX, CFG_DATA_W'(sb));
    set_reg(CFG_WAYS_IN_USE, CFG_DATA_W'(nw));
  endtask

  // one access transfer; valid stays high when the next item follows at once
  task automatic send_access(logic [ABITS-1:0] a, logic wr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    address_i <= a;
    is_write_i <= wr;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(cache_access(a, wr));
  endtask

  // wait for all results, then let the pipeline settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_idling(int unsigned s, int unsigned r);
    send_idle_pct = s;
    recv_stall_pct = r;
  endtask

  function automatic logic [ABITS-1:0] pick_addr();
    int unsigned mode;
    mode = $urandom_range(99);
    if (mode < 75)
      return hot_addr[$urandom_range(15)]
             + (ABITS'($urandom_range(3)) << model_cfg.block_offset_bits)
             + ABITS'($urandom_range(63));
    if (mode < 88) return ABITS'({$urandom, $urandom});
    return '1 - ABITS'($urandom_range(4095));
  endfunction

  task automatic refill_hot();
    for (int i = 0; i < 16; i++)
      hot_addr[i] = (i < 8) ? ABITS'({$urandom, $urandom})
                            : ABITS'($urandom_range(65535)) << 4;
  endtask

  // default settings: one set, eight ways, fifo; fill, hit, evict, extremes
  task automatic test_fill_and_evict();
    set_idling(0, 0);
    send_access('0, 1'b0);
    send_access('0, 1'b1);
    send_access('1, 1'b1);
    send_access(ABITS'(1) << (ABITS - 1), 1'b0);
    for (int k = 1; k <= 8; k++) send_access(ABITS'(k) << 5, k[0]);
    send_access('0, 1'b0);
    send_access('1, 1'b0);
    drain();
  endtask

  // lru with prefetch, including wrap of the next block past the top
  task automatic test_lru_prefetch();
    set_all(1'b1, 1'b1, 5'd4, 4'd2, 4'd2);
    set_idling(0, 70);
    send_access('1, 1'b0);
    send_access('0, 1'b1);
    send_access(ABITS'(16), 1'b0);
    send_access(ABITS'(16), 1'b0);
    send_access(ABITS'(64), 1'b1);
    send_access(ABITS'(256), 1'b0);
    send_access(ABITS'(64), 1'b0);
    send_access(ABITS'(512), 1'b0);
    drain();
  endtask

  // out-of-range settings and ignored register indexes
  task automatic test_odd_settings();
    set_all(1'b0, 1'b1, 5'd0, 4'd15, 4'd0);
    set_reg(CFG_UNUSED_IDX, 5'd31);
    set_reg(CFG_UNUSED_IDX + 2'd2, 5'd0);
    set_idling(70, 0);
    for (int k = 0; k < 4; k++) send_access(ABITS'(k * 1024), k[0]);
    send_access('0, 1'b0);
    drain();
    set_all(1'b1, 1'b1, 5'd31, 4'd11, 4'd15);
    set_reg(CFG_UNUSED_IDX + 1'b1, 5'd7);
    send_access('1, 1'b1);
    send_access('0, 1'b0);
    drain();
  endtask

  // random traffic over a series of settings and idling patterns
  task automatic test_random_traffic();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: set_idling(0, 0);
        1: set_idling(70, 0);
        2: set_idling(0, 70);
        default: set_idling(36, 36);
      endcase
      if (ph == 3) set_all(1'b1, 1'b1, 5'd16, 4'd10, 4'd8);
      else if (ph == 6) set_all(1'b0, 1'b0, 5'd0, 4'd0, 4'd1);
      else begin
        set_all(1'($urandom_range(1)), 1'($urandom_range(1)), 5'($urandom_range(16)),
                4'($urandom_range(15)), 4'($urandom_range(15)));
        if ($urandom_range(1)) set_reg(CFG_UNUSED_IDX + 2'($urandom_range(2)),
                                       CFG_DATA_W'($urandom));
      end
      refill_hot();
      for (int i = 0; i < 95; i++) send_access(pick_addr(), 1'($urandom_range(1)));
      drain();
    end
  endtask

  // receiver stall
  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  // result check against the oldest prediction
  always @(posedge clk_i) begin
    access_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t result transfer with no access outstanding", $realtime);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (hit_o !== want.hit) report_mismatch("hit", 32'(hit_o), 32'(want.hit));
        if (demand_fill_o !== want.demand_fill)
          report_mismatch("demand_fill", 32'(demand_fill_o), 32'(want.demand_fill));
        if (prefetch_fill_o !== want.prefetch_fill)
          report_mismatch("prefetch_fill", 32'(prefetch_fill_o), 32'(want.prefetch_fill));
        if (memory_write_o !== want.memory_write)
          report_mismatch("memory_write", 32'(memory_write_o), 32'(want.memory_write));
        if (reads_total_o !== want.reads)
          report_mismatch("reads_total", reads_total_o, want.reads);
        if (writes_total_o !== want.writes)
          report_mismatch("writes_total", writes_total_o, want.writes);
        if (hits_total_o !== want.hits)
          report_mismatch("hits_total", hits_total_o, want.hits);
        if (misses_total_o !== want.misses)
          report_mismatch("misses_total", misses_total_o, want.misses);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("set_assoc_cache_with_prefetch_top regression: fail");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    address_i = '0;
    is_write_i = 1'b0;
    out_stall_i = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fail_count = 0;
    quiet_cycles = 0;
    cnt_reads = '0;
    cnt_writes = '0;
    cnt_hits = '0;
    cnt_misses = '0;
    model_cfg = '{lru_policy: 1'b0, prefetch_enable: 1'b0,
                  block_offset_bits: RST_BLOCK_OFFSET, set_index_bits: RST_SET_INDEX,
                  ways_in_use: RST_WAYS_IN_USE};
    for (int i = 0; i < LINES; i++) begin
      line_ok[i] = 1'b0;
      line_tag[i] = '0;
      line_rank[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_and_evict();
    test_lru_prefetch();
    test_odd_settings();
    test_random_traffic();
    drain();
    if (fail_count == 0) $display("set_assoc_cache_with_prefetch_top regression: pass");
    else $display("set_assoc_cache_with_prefetch_top regression: fail");
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
rtl/core/sacp_pkg.sv
rtl/core/sacp_ram.sv
rtl/core/sacp_front.sv
rtl/core/sacp_back.sv
rtl/core/set_assoc_cache_with_prefetch_top.sv
bench/set_assoc_cache_with_prefetch_top_test.sv
